[src/biou_pkg.sv]
// Shared widths, types and constants for the box IoU pipeline.
// No dependencies; compiled first.
package biou_pkg;

  // Fixed point format of the result
  localparam int FRAC_BITS = 16;
  localparam int IOU_W     = FRAC_BITS + 1;

  // Field widths
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int THR_W   = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd13107;

  // Doubled edges: 2c +/- w
  localparam int EDGE_W  = COORD_W + 2;
  localparam int DIFF_W  = EDGE_W + 1;
  // Doubled overlap is at most 2 * (2^SIZE_W - 1)
  localparam int OVL_W   = SIZE_W + 1;
  localparam int PROD_W  = 2 * SIZE_W;
  localparam int INTER_W = 2 * OVL_W;
  // Four times the area of each box, summed
  localparam int AREA_W  = PROD_W + 3;
  localparam int REM_W   = AREA_W + 1;

  // One divider cell per quotient bit
  localparam int NUM_CELLS = IOU_W;

  localparam int CMP_W = (IOU_W > THR_W) ? IOU_W : THR_W;

  // Request traveling down the divider chain
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [AREA_W-1:0] dvs;
    logic [IOU_W-1:0]  quo;
    logic              zu;
  } div_t;

endpackage

[src/biou_in_if.sv]
// Input channel: one box pair per request, valid/ready handshake.
// Depends on biou_pkg.
interface biou_in_if;
  import biou_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  test_center_x;
  logic signed [COORD_W-1:0]  test_center_y;
  logic        [SIZE_W-1:0]   test_width;
  logic        [SIZE_W-1:0]   test_height;
  logic signed [COORD_W-1:0]  ref_center_x;
  logic signed [COORD_W-1:0]  ref_center_y;
  logic        [SIZE_W-1:0]   ref_width;
  logic        [SIZE_W-1:0]   ref_height;

  modport source (
    output valid, test_center_x, test_center_y, test_width, test_height,
           ref_center_x, ref_center_y, ref_width, ref_height,
    input  ready
  );
  modport sink (
    input  valid, test_center_x, test_center_y, test_width, test_height,
           ref_center_x, ref_center_y, ref_width, ref_height,
    output ready
  );
endinterface

[src/biou_out_if.sv]
// Result channel: IoU and flags per request, valid/ready handshake.
// Depends on biou_pkg.
interface biou_out_if;
  import biou_pkg::*;

  logic             valid;
  logic             ready;
  logic [IOU_W-1:0] iou;
  logic             above_threshold;
  logic             zero_union;

  modport source (output valid, iou, above_threshold, zero_union, input ready);
  modport sink   (input valid, iou, above_threshold, zero_union, output ready);
endinterface

[src/biou_front.sv]
// Geometry stages: doubled edges, clamped overlaps, areas and union.
// Four registered stages feeding the divider chain. Depends on biou_pkg, biou_in_if.
module biou_front (
  input  logic              clk,
  input  logic              rst_n,
  biou_in_if.sink           in_ch,
  output logic              dn_valid,
  input  logic              dn_ready,
  output biou_pkg::div_t    dn_data
);
  import biou_pkg::*;

  // Doubled overlap of two intervals, clamped at zero
  function automatic logic [OVL_W-1:0] overlap2(
    input logic signed [EDGE_W-1:0] a_lo, input logic signed [EDGE_W-1:0] a_hi,
    input logic signed [EDGE_W-1:0] b_lo, input logic signed [EDGE_W-1:0] b_hi
  );
    logic signed [EDGE_W-1:0] lo;
    logic signed [EDGE_W-1:0] hi;
    logic signed [DIFF_W-1:0] d;
    lo = (a_lo > b_lo) ? a_lo : b_lo;
    hi = (a_hi < b_hi) ? a_hi : b_hi;
    d  = $signed({hi[EDGE_W-1], hi}) - $signed({lo[EDGE_W-1], lo});
    overlap2 = (d > 0) ? d[OVL_W-1:0] : '0;
  endfunction

  function automatic logic signed [EDGE_W-1:0] dbl(input logic signed [COORD_W-1:0] c);
    dbl = $signed({{(EDGE_W-COORD_W-1){c[COORD_W-1]}}, c, 1'b0});
  endfunction

  function automatic logic signed [EDGE_W-1:0] ext(input logic [SIZE_W-1:0] w);
    ext = $signed({{(EDGE_W-SIZE_W){1'b0}}, w});
  endfunction

  // Stage valids and ready chain (bubbles collapse)
  logic v1_r, v2_r, v3_r, v4_r;
  logic r1, r2, r3, r4;

  assign r4 = !v4_r || dn_ready;
  assign r3 = !v3_r || r4;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign in_ch.ready = r1;

  // Stage 1: doubled edges
  logic signed [EDGE_W-1:0] txl_r, txh_r, tyl_r, tyh_r;
  logic signed [EDGE_W-1:0] rxl_r, rxh_r, ryl_r, ryh_r;
  logic [SIZE_W-1:0]        tw_r, th_r, rw_r, rh_r;

  // Stage 2: overlaps and area products
  logic [OVL_W-1:0]  ix_r, iy_r;
  logic [PROD_W-1:0] pt_r, pr_r;

  // Stage 3: intersection and area sum
  logic [INTER_W-1:0] inter_r;
  logic [AREA_W-1:0]  asum_r;

  // Stage 4: union
  logic [INTER_W-1:0] inter4_r;
  logic [AREA_W-1:0]  uni_r;

  logic [AREA_W-1:0] uni_nxt;
  assign uni_nxt = asum_r - AREA_W'(inter_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_ch.valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_ch.valid) begin
      txl_r <= dbl(in_ch.test_center_x) - ext(in_ch.test_width);
      txh_r <= dbl(in_ch.test_center_x) + ext(in_ch.test_width);
      tyl_r <= dbl(in_ch.test_center_y) - ext(in_ch.test_height);
      tyh_r <= dbl(in_ch.test_center_y) + ext(in_ch.test_height);
      rxl_r <= dbl(in_ch.ref_center_x) - ext(in_ch.ref_width);
      rxh_r <= dbl(in_ch.ref_center_x) + ext(in_ch.ref_width);
      ryl_r <= dbl(in_ch.ref_center_y) - ext(in_ch.ref_height);
      ryh_r <= dbl(in_ch.ref_center_y) + ext(in_ch.ref_height);
      tw_r  <= in_ch.test_width;
      th_r  <= in_ch.test_height;
      rw_r  <= in_ch.ref_width;
      rh_r  <= in_ch.ref_height;
    end
    if (r2 && v1_r) begin
      ix_r <= overlap2(txl_r, txh_r, rxl_r, rxh_r);
      iy_r <= overlap2(tyl_r, tyh_r, ryl_r, ryh_r);
      pt_r <= PROD_W'(tw_r) * PROD_W'(th_r);
      pr_r <= PROD_W'(rw_r) * PROD_W'(rh_r);
    end
    if (r3 && v2_r) begin
      inter_r <= INTER_W'(ix_r) * INTER_W'(iy_r);
      // Doubled sides give four times each area
      asum_r  <= {1'b0, pt_r, 2'b00} + {1'b0, pr_r, 2'b00};
    end
    if (r4 && v3_r) begin
      inter4_r <= inter_r;
      uni_r    <= uni_nxt;
    end
  end

  // Divider seed: remainder starts at the intersection
  assign dn_valid     = v4_r;
  assign dn_data.rem  = REM_W'(inter4_r);
  assign dn_data.dvs  = uni_r;
  assign dn_data.quo  = '0;
  assign dn_data.zu   = (uni_r == '0);

endmodule

[src/biou_div_cell.sv]
// One restoring-division cell: resolves one quotient bit per request.
// Depends on biou_pkg.
module biou_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  biou_pkg::div_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output biou_pkg::div_t dn_data
);
  import biou_pkg::*;

  logic             valid_r;
  div_t             data_r;
  logic [REM_W-1:0] dext;
  logic [REM_W-1:0] diff;
  logic             qbit;
  div_t             data_nxt;

  assign up_ready = !valid_r || dn_ready;

  // Compare, subtract, shift for the next bit
  always_comb begin
    dext     = {1'b0, up_data.dvs};
    diff     = up_data.rem - dext;
    qbit     = (up_data.rem >= dext);
    data_nxt = up_data;
    data_nxt.rem = qbit ? {diff[REM_W-2:0], 1'b0} : {up_data.rem[REM_W-2:0], 1'b0};
    data_nxt.quo = {up_data.quo[IOU_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/box_iou_2d.sv]
// Box IoU top level: geometry front end, chain of divider cells, output stage.
// Depends on biou_pkg, biou_in_if, biou_out_if, biou_front, biou_div_cell.
//
// Takes one pair of center/size boxes per request and returns their IoU as an
// unsigned Q1.16 fraction (65536 is 1.0, truncated), with a zero-union flag
// (both boxes empty, IoU forced to 0) and a flag for IoU >= match_threshold.
// A new pair is accepted every cycle while the output is not stalled; each result
// passes through four geometry stages, seventeen divider cells resolving one
// quotient bit each, and the output register, the first stage loading on the
// accepting edge. Stalls on the output back up stage by stage, and empty stages
// keep accepting. The threshold is written through cfg_we/cfg_wdata and resets
// to 13107 (0.2).
module box_iou_2d (
  input  logic                         clk,
  input  logic                         rst_n,
  biou_in_if.sink                      in_ch,
  biou_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [biou_pkg::THR_W-1:0]   cfg_wdata
);
  import biou_pkg::*;

  // Threshold register
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // Divider chain links
  logic cv [NUM_CELLS+1];
  logic cr [NUM_CELLS+1];
  div_t cd [NUM_CELLS+1];

  biou_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (cv[0]),
    .dn_ready (cr[0]),
    .dn_data  (cd[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    biou_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[i]),
      .up_ready (cr[i]),
      .up_data  (cd[i]),
      .dn_valid (cv[i+1]),
      .dn_ready (cr[i+1]),
      .dn_data  (cd[i+1])
    );
  end

  // Output register
  logic             out_valid_r;
  logic [IOU_W-1:0] iou_r;
  logic             above_r;
  logic             zu_r;
  logic [IOU_W-1:0] iou_nxt;
  logic             above_nxt;

  assign cr[NUM_CELLS] = !out_valid_r || out_ch.ready;

  always_comb begin
    iou_nxt   = cd[NUM_CELLS].zu ? '0 : cd[NUM_CELLS].quo;
    above_nxt = (CMP_W'(iou_nxt) >= CMP_W'(thr_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cr[NUM_CELLS]) begin
      out_valid_r <= cv[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (cr[NUM_CELLS] && cv[NUM_CELLS]) begin
      iou_r   <= iou_nxt;
      above_r <= above_nxt;
      zu_r    <= cd[NUM_CELLS].zu;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.iou             = iou_r;
  assign out_ch.above_threshold = above_r;
  assign out_ch.zero_union      = zu_r;

endmodule

[src/biou_checker.sv]
// Port-level checks for box_iou_2d, attached by bind.
// Depends on biou_pkg and box_iou_2d.
module biou_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [biou_pkg::IOU_W-1:0] iou,
  input logic                       zero_union
);
  import biou_pkg::*;

  localparam logic [IOU_W-1:0] ONE = IOU_W'(1) << FRAC_BITS;

  // Nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Empty union forces a zero ratio
  a_zu: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_union |-> iou == '0)
    else $error("nonzero iou with zero union");

  // Ratio never exceeds one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> iou <= ONE)
    else $error("iou above one");

endmodule

bind box_iou_2d biou_checker u_biou_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .iou        (out_ch.iou),
  .zero_union (out_ch.zero_union)
);

[sim/tb_box_iou_2d.sv]
// Self-checking testbench for box_iou_2d: streams box pairs through the IoU pipeline
// and compares every result with an in-bench IoU calculation.
// Depends on biou_pkg, biou_in_if, biou_out_if and the box_iou_2d RTL.
module tb_box_iou_2d;
  timeunit 1ns;
  timeprecision 1ps;
  import biou_pkg::*;

  localparam int MAX_WAIT    = 12;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AT_A   = 450;
  localparam int HOLD_AT_B   = 1700;
  localparam int DRAIN_WAIT  = 40;
  localparam int STALL_LIMIT = 4000;

  // One box pair as it travels on the input channel
  typedef struct packed {
    logic signed [COORD_W-1:0] tcx;
    logic signed [COORD_W-1:0] tcy;
    logic        [SIZE_W-1:0]  tw;
    logic        [SIZE_W-1:0]  th;
    logic signed [COORD_W-1:0] rcx;
    logic signed [COORD_W-1:0] rcy;
    logic        [SIZE_W-1:0]  rw;
    logic        [SIZE_W-1:0]  rh;
  } box_pair_t;

  typedef struct packed {
    logic [IOU_W-1:0] iou;
    logic             above;
    logic             zu;
  } iou_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  biou_in_if  in_bus();
  biou_out_if out_bus();

  box_iou_2d i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  box_pair_t box_pair_q[$];
  iou_res_t  iou_expq[$];
  logic [THR_W-1:0] match_thr = THR_RESET;
  bit src_busy;
  bit snk_busy;
  int n_errors;
  int n_sent;
  int n_results;
  int n_above;
  int n_zero_union;
  int n_settings;

  // Doubled overlap of two doubled intervals, clamped at zero
  function automatic longint overlap_len(longint a_lo, longint a_hi,
                                         longint b_lo, longint b_hi);
    longint lo;
    longint hi;
    lo = (a_lo > b_lo) ? a_lo : b_lo;
    hi = (a_hi < b_hi) ? a_hi : b_hi;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // IoU of one pair, Q1.FRAC_BITS truncated, plus both flags
  function automatic iou_res_t predict_iou(box_pair_t p, logic [THR_W-1:0] thr);
    longint tcx2;
    longint tcy2;
    longint rcx2;
    longint rcy2;
    longint tw;
    longint th;
    longint rw;
    longint rh;
    longint unsigned inter;
    longint unsigned uni;
    longint unsigned q;
    iou_res_t r;
    tcx2 = 2 * longint'(p.tcx);
    tcy2 = 2 * longint'(p.tcy);
    rcx2 = 2 * longint'(p.rcx);
    rcy2 = 2 * longint'(p.rcy);
    tw = longint'(p.tw);
    th = longint'(p.th);
    rw = longint'(p.rw);
    rh = longint'(p.rh);
    inter = overlap_len(tcx2 - tw, tcx2 + tw, rcx2 - rw, rcx2 + rw)
          * overlap_len(tcy2 - th, tcy2 + th, rcy2 - rh, rcy2 + rh);
    uni = (4 * tw * th) + (4 * rw * rh) - inter;
    q = 0;
    r.zu = (uni == 0);
    if (uni != 0) begin
      q = (inter << FRAC_BITS) / uni;
    end
    r.iou = q[IOU_W-1:0];
    r.above = (q >= longint'(thr));
    return r;
  endfunction

  function automatic box_pair_t mk_pair(int tcx, int tcy, int tw, int th,
                                        int rcx, int rcy, int rw, int rh);
    box_pair_t p;
    p.tcx = COORD_W'(tcx);
    p.tcy = COORD_W'(tcy);
    p.tw  = SIZE_W'(tw);
    p.th  = SIZE_W'(th);
    p.rcx = COORD_W'(rcx);
    p.rcy = COORD_W'(rcy);
    p.rw  = SIZE_W'(rw);
    p.rh  = SIZE_W'(rh);
    return p;
  endfunction

  // Append a pair to the driver's pending list
  function automatic void add_pair(box_pair_t p);
    box_pair_q.insert(box_pair_q.size(), p);
  endfunction

  // Mostly small boxes, now and then one of any size
  function automatic int pick_size();
    return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32767))
                                       : int'($urandom_range(0, 300));
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t p;
    int kind;
    int span;
    int dx;
    int dy;
    kind = $urandom_range(0, 9);
    p = mk_pair($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    if (kind >= 2 && kind <= 7) begin
      // Boxes placed near each other so that most of them overlap
      p.tw = SIZE_W'(pick_size());
      p.th = SIZE_W'(pick_size());
      p.rw = SIZE_W'(pick_size());
      p.rh = SIZE_W'(pick_size());
      span = (int'(p.tw) + int'(p.rw)) / 2 + 2;
      dx = int'($urandom_range(0, 2 * span)) - span;
      span = (int'(p.th) + int'(p.rh)) / 2 + 2;
      dy = int'($urandom_range(0, 2 * span)) - span;
      p.rcx = COORD_W'(int'(p.tcx) + dx);
      p.rcy = COORD_W'(int'(p.tcy) + dy);
    end else if (kind == 8) begin
      // Concentric boxes, sometimes identical
      p.rcx = p.tcx;
      p.rcy = p.tcy;
      if ($urandom_range(0, 1) == 0) begin
        p.rw = p.tw;
        p.rh = p.th;
      end
    end else if (kind == 9) begin
      // Degenerate boxes: flat, thin or empty
      p.tw = $urandom_range(0, 1) ? SIZE_W'(0) : p.tw;
      p.th = $urandom_range(0, 1) ? SIZE_W'(0) : p.th;
      p.rw = $urandom_range(0, 1) ? SIZE_W'(0) : p.rw;
      p.rh = $urandom_range(0, 1) ? SIZE_W'(0) : p.rh;
    end
    return p;
  endfunction

  function automatic int draw_wait(bit busy);
    return busy ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("ERROR %0t ns: %s", $realtime, msg);
    n_errors++;
  endtask

  // Input driver: offers queued pairs, predicts each accepted request
  box_pair_t cur_pair;
  int src_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        iou_expq.insert(iou_expq.size(), predict_iou(cur_pair, match_thr));
        n_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_bus.valid <= 1'b0;
        end else if (box_pair_q.size() > 0) begin
          cur_pair = box_pair_q.pop_front();
          in_bus.test_center_x <= cur_pair.tcx;
          in_bus.test_center_y <= cur_pair.tcy;
          in_bus.test_width    <= cur_pair.tw;
          in_bus.test_height   <= cur_pair.th;
          in_bus.ref_center_x  <= cur_pair.rcx;
          in_bus.ref_center_y  <= cur_pair.rcy;
          in_bus.ref_width     <= cur_pair.rw;
          in_bus.ref_height    <= cur_pair.rh;
          in_bus.valid         <= 1'b1;
          src_gap = draw_wait(src_busy);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result, then pauses ready for a drawn time
  int snk_wait;
  iou_res_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        if (out_bus.above_threshold) n_above++;
        if (out_bus.zero_union) n_zero_union++;
        if (iou_expq.size() == 0) begin
          flag_mismatch("result arrived with no request outstanding");
        end else begin
          want = iou_expq.pop_front();
          if (out_bus.iou !== want.iou)
            flag_mismatch($sformatf("result %0d: iou %0d, want %0d",
                                    n_results, out_bus.iou, want.iou));
          if (out_bus.above_threshold !== want.above)
            flag_mismatch($sformatf("result %0d: above_threshold %b, want %b",
                                    n_results, out_bus.above_threshold, want.above));
          if (out_bus.zero_union !== want.zu)
            flag_mismatch($sformatf("result %0d: zero_union %b, want %b",
                                    n_results, out_bus.zero_union, want.zu));
        end
        // long back-pressure twice in the run so the pipeline fills
        if (n_results == HOLD_AT_A || n_results == HOLD_AT_B)
          snk_wait = LONG_HOLD;
        else
          snk_wait = draw_wait(snk_busy);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  int stall_cycles;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb_box_iou_2d NOT OK");
        $finish;
      end
    end
  end

  // Wait until every request is sent and every result is back, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (box_pair_q.size() != 0 || in_bus.valid || iou_expq.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] thr);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    match_thr = thr;
    n_settings++;
  endtask

  task automatic run_random(logic [THR_W-1:0] thr, int count, bit src_idle, bit snk_idle);
    write_threshold(thr);
    @(negedge clk);
    src_busy = src_idle;
    snk_busy = snk_idle;
    repeat (count) add_pair(random_pair());
    wait_drained();
  endtask

  initial begin
    in_bus.valid         = 1'b0;
    in_bus.test_center_x = '0;
    in_bus.test_center_y = '0;
    in_bus.test_width    = '0;
    in_bus.test_height   = '0;
    in_bus.ref_center_x  = '0;
    in_bus.ref_center_y  = '0;
    in_bus.ref_width     = '0;
    in_bus.ref_height    = '0;
    out_bus.ready        = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    rst_n                = 1'b0;
    src_busy             = 1'b1;
    snk_busy             = 1'b1;
    n_settings           = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs under the reset threshold
    @(negedge clk);
    add_pair(mk_pair(0, 0, 10, 10, 0, 0, 10, 10));             // identical
    add_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0));                 // both empty
    add_pair(mk_pair(5, -7, 20, 0, 300, 40, 0, 9));            // both flat
    add_pair(mk_pair(0, 0, 0, 0, 0, 0, 10, 10));               // one empty
    add_pair(mk_pair(0, 0, 10, 10, 100, 100, 10, 10));         // disjoint
    add_pair(mk_pair(0, 0, 10, 10, 10, 0, 10, 10));            // touching in x
    add_pair(mk_pair(0, 0, 10, 10, 0, -10, 10, 10));           // touching in y
    add_pair(mk_pair(0, 0, 100, 100, 0, 0, 10, 10));           // nested
    add_pair(mk_pair(0, 0, 10, 10, 5, 0, 10, 10));             // half shifted
    add_pair(mk_pair(-32768, 32767, 32767, 32767,
                     -32768, 32767, 32767, 32767));             // extreme, equal
    add_pair(mk_pair(32767, -32768, 32767, 32767,
                     -32768, 32767, 32767, 32767));             // opposite corners
    add_pair(mk_pair(-32768, -32768, 32767, 32767,
                     0, 0, 32767, 32767));                      // large, disjoint
    add_pair(mk_pair(7, 7, 1, 1, 7, 7, 1, 1));                 // unit, equal
    add_pair(mk_pair(7, 7, 1, 1, 8, 7, 1, 1));                 // unit, touching
    add_pair(mk_pair(0, 0, 1, 1, 0, 0, 32767, 32767));         // tiny inside huge
    add_pair(mk_pair(16'h5555, 16'haaaa, 15'h2aaa, 15'h5555,
                     16'haaaa, 16'h5555, 15'h5555, 15'h2aaa)); // bit patterns
    add_pair(mk_pair(0, 0, 32767, 32767, 32767, 32767, 32767, 32767));
    add_pair(mk_pair(100, 100, 40, 30, 110, 95, 30, 40));      // partial overlap
    wait_drained();

    // Random phases across the threshold range; zero, one and above one included
    run_random(THR_W'(0),      300, 1'b1, 1'b1);
    run_random(THR_W'(65536),  300, 1'b0, 1'b1);
    run_random('1,             200, 1'b1, 1'b0);
    run_random(THR_W'($urandom_range(1, 65535)), 400, 1'b1, 1'b1);
    run_random(THR_W'($urandom_range(1, 65535)), 400, 1'b0, 1'b0);
    run_random(THR_W'($urandom_range(1, 65535)), 400, 1'b1, 1'b1);

    $display("Sent %0d box pairs over %0d threshold settings, %0d results checked",
             n_sent, n_settings, n_results);
    $display("%0d results matched the threshold, %0d had an empty union",
             n_above, n_zero_union);
    if (n_errors == 0) begin
      $display("tb_box_iou_2d OK");
    end else begin
      $display("tb_box_iou_2d NOT OK");
    end
    $finish;
  end

endmodule
